/* hdl/cooperative_task_scheduler_top_assert.svh */
// Assertion macros for the scheduler. Both sample on clk_i and are off while rst_ni is low.
`ifndef COOPERATIVE_TASK_SCHEDULER_TOP_ASSERT_SVH
`define COOPERATIVE_TASK_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cts_pkg.sv */
`timescale 1ns / 1ps
package cts_pkg;

  // Operation codes on the input beat.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_DISP = 2'd3;

  // Status codes on the output beat.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  // Latched error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_DEL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       rd_en;
    logic       walk_fire;
    logic [1:0] op;
  } cts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic walk_emit;
    logic none_ready;
  } cts_sts_t;

endpackage

/* hdl/cooperative_task_scheduler_top.sv */
`timescale 1ns / 1ps
// Channel  | Direction | Handshake               | Beat
// input    | in        | in_valid_i / in_stall_o | op, task_tag, first_delay, period, slot_index
// output   | out       | out_valid_o/out_stall_i | status, slot, run_tag, last_result, last_error
//
// Add, delete and a dispatch with nothing ready go through the exec state, which loads the
// output register once it is free. Tick and dispatch walk one slot a cycle, save where a beat
// waits for the output, through the single, registered read port of the slot memories.
// A stalled output pauses a dispatch walk at the next slot that has a run to report.
// Reset is asynchronous and marks every slot free; there is no clearing pass.
module cooperative_task_scheduler_top #(
  parameter int MAX_TASKS      = 8,
  parameter int RUN_COUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] task_tag_i,
  input  logic [31:0] first_delay_i,
  input  logic [31:0] period_i,
  input  logic [5:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [6:0]  slot_o,
  output logic [15:0] run_tag_o,
  output logic        last_result_o,
  output logic [1:0]  last_error_o
);
  import cts_pkg::*;

  localparam int SlotW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  cts_cmd_t         cmd;
  cts_sts_t         sts;
  logic [SlotW-1:0] rd_idx;
  logic [SlotW-1:0] walk_idx;

  // Sequencer for operations and slot walks.
  cts_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .SLOT_W    (SlotW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx),
    .walk_idx_o (walk_idx)
  );

  // Slot table, error latch and output register.
  cts_datapath #(
    .MAX_TASKS      (MAX_TASKS),
    .RUN_COUNT_BITS (RUN_COUNT_BITS),
    .SLOT_W         (SlotW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_idx_i      (rd_idx),
    .walk_idx_i    (walk_idx),
    .sts_o         (sts),
    .task_tag_i    (task_tag_i),
    .first_delay_i (first_delay_i),
    .period_i      (period_i),
    .slot_index_i  (slot_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .run_tag_o     (run_tag_o),
    .last_result_o (last_result_o),
    .last_error_o  (last_error_o)
  );

`include "cooperative_task_scheduler_top_assert.svh"

  // An accepted beat keeps the block busy for at least the next cycle.
  `CTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted twice in a row")

  // A beat that reports nothing ready names no slot and ends the operation.
  `CTS_ASSERT_NOW(a_none_ready_form, out_valid_o && status_o == ST_NONE, slot_o == 7'(MAX_TASKS) && last_result_o, "bad nothing-ready beat")

  // Every beat with a status other than OK carries a zero tag and is final.
  `CTS_ASSERT_NOW(a_non_dispatch_form, out_valid_o && status_o != ST_OK, run_tag_o == 16'd0 && last_result_o, "bad error beat")

endmodule

/* hdl/cts_ctrl.sv */
`timescale 1ns / 1ps
module cts_ctrl #(
  parameter int MAX_TASKS = 8,
  parameter int SLOT_W    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  cts_pkg::cts_sts_t sts_i,
  output cts_pkg::cts_cmd_t cmd_o,
  output logic [SLOT_W-1:0] rd_idx_o,
  output logic [SLOT_W-1:0] walk_idx_o
);
  import cts_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(MAX_TASKS - 1);

  logic [1:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [SLOT_W-1:0] walk_q, walk_d;

  // Next-state and command decode.
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    walk_d     = walk_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    rd_idx_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = op_i;
          if (op_i == OP_TICK || (op_i == OP_DISP && !sts_i.none_ready)) begin
            state_d     = S_WALK;
            walk_d      = '0;
            cmd_o.rd_en = 1'b1;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_WALK: begin
        if (!sts_i.walk_emit || sts_i.out_free) begin
          cmd_o.walk_fire = 1'b1;
          if (walk_q == LastIdx) begin
            state_d = S_IDLE;
          end else begin
            walk_d      = walk_q + SLOT_W'(1);
            cmd_o.rd_en = 1'b1;
            rd_idx_o    = walk_q + SLOT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      walk_q  <= walk_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign walk_idx_o = walk_q;

endmodule

/* hdl/cts_datapath.sv */
`timescale 1ns / 1ps
module cts_datapath #(
  parameter int MAX_TASKS      = 8,
  parameter int RUN_COUNT_BITS = 8,
  parameter int SLOT_W         = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cts_pkg::cts_cmd_t cmd_i,
  input  logic [SLOT_W-1:0] rd_idx_i,
  input  logic [SLOT_W-1:0] walk_idx_i,
  output cts_pkg::cts_sts_t sts_o,
  input  logic [15:0]       task_tag_i,
  input  logic [31:0]       first_delay_i,
  input  logic [31:0]       period_i,
  input  logic [5:0]        slot_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [6:0]        slot_o,
  output logic [15:0]       run_tag_o,
  output logic              last_result_o,
  output logic [1:0]        last_error_o
);
  import cts_pkg::*;

  localparam logic [SLOT_W-1:0]         LastIdx  = SLOT_W'(MAX_TASKS - 1);
  localparam logic [6:0]                SlotNone = 7'(MAX_TASKS);
  localparam logic [RUN_COUNT_BITS-1:0] RunMax   = '1;

  // Slot memories, one entry per task slot.
  logic [15:0]               tag_mem [MAX_TASKS];
  logic [31:0]               dly_mem [MAX_TASKS];
  logic [31:0]               per_mem [MAX_TASKS];
  logic [RUN_COUNT_BITS-1:0] run_mem [MAX_TASKS];

  logic [15:0]               rd_tag_q;
  logic [31:0]               rd_dly_q;
  logic [31:0]               rd_per_q;
  logic [RUN_COUNT_BITS-1:0] rd_run_q;

  // Occupancy, runs-pending flags and error latch.
  logic [MAX_TASKS-1:0] occ_q, occ_d;
  logic [MAX_TASKS-1:0] pnz_q, pnz_d;
  logic [1:0]           err_q, err_d;

  // Operands of the beat being worked on.
  logic [15:0] tag_q;
  logic [31:0] dly_q;
  logic [31:0] per_q;
  logic [5:0]  sidx_q;

  // Output register.
  logic        out_vld_q;
  logic [2:0]  o_status_q, o_status_d;
  logic [6:0]  o_slot_q, o_slot_d;
  logic [15:0] o_tag_q, o_tag_d;
  logic        o_last_q, o_last_d;
  logic        o_load;

  logic                      found;
  logic [SLOT_W-1:0]         free_idx;
  logic                      add_wr;
  logic                      live;
  logic [15:0]               w_tag;
  logic [31:0]               w_dly;
  logic [31:0]               w_per;
  logic [RUN_COUNT_BITS-1:0] w_run;
  logic [31:0]               dly_nx;
  logic [RUN_COUNT_BITS-1:0] run_nx;
  logic                      run_nz;
  logic                      later;
  logic                      is_tick;
  logic                      is_disp;

  // First free slot, lowest index wins.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (!found && !occ_q[i]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Slot under the walk; a free slot reads as all zero.
  assign live  = occ_q[walk_idx_i];
  assign w_tag = live ? rd_tag_q : '0;
  assign w_dly = live ? rd_dly_q : '0;
  assign w_per = live ? rd_per_q : '0;
  assign w_run = live ? rd_run_q : '0;

  assign is_tick = (cmd_i.op == OP_TICK);
  assign is_disp = (cmd_i.op == OP_DISP);
  assign run_nz  = (w_run != '0);

  // Per-slot update for tick and dispatch.
  always_comb begin
    dly_nx = w_dly;
    run_nx = w_run;
    if (is_tick) begin
      if (w_dly == 32'd0) begin
        if (w_run != RunMax) begin
          run_nx = w_run + RUN_COUNT_BITS'(1);
        end
        if (w_per != 32'd0) begin
          dly_nx = w_per;
        end
      end else begin
        dly_nx = w_dly - 32'd1;
      end
    end else begin
      run_nx = w_run - RUN_COUNT_BITS'(1);
    end
  end

  // Any slot above the current one still has runs pending.
  always_comb begin
    later = 1'b0;
    for (int j = 0; j < MAX_TASKS; j++) begin
      if (SLOT_W'(j) > walk_idx_i && pnz_q[j]) begin
        later = 1'b1;
      end
    end
  end

  assign add_wr = cmd_i.exec && (cmd_i.op == OP_ADD) && (tag_q != 16'd0) && found;

  // Control updates and the next output beat.
  always_comb begin
    occ_d      = occ_q;
    pnz_d      = pnz_q;
    err_d      = err_q;
    o_load     = 1'b0;
    o_status_d = ST_OK;
    o_slot_d   = SlotNone;
    o_tag_d    = '0;
    o_last_d   = 1'b1;
    if (cmd_i.exec) begin
      o_load = 1'b1;
      case (cmd_i.op)
        OP_ADD: begin
          if (tag_q == 16'd0) begin
            o_status_d = ST_BAD;
          end else if (!found) begin
            err_d      = ERR_FULL;
            o_status_d = ST_FULL;
          end else begin
            occ_d[free_idx] = 1'b1;
            pnz_d[free_idx] = 1'b0;
            o_slot_d        = 7'(free_idx);
          end
        end
        OP_DEL: begin
          if ({1'b0, sidx_q} >= SlotNone) begin
            o_status_d = ST_BAD;
          end else begin
            if (!occ_q[sidx_q[SLOT_W-1:0]]) begin
              err_d      = ERR_DEL;
              o_status_d = ST_EMPTY;
            end
            occ_d[sidx_q[SLOT_W-1:0]] = 1'b0;
            pnz_d[sidx_q[SLOT_W-1:0]] = 1'b0;
          end
        end
        default: begin
          o_status_d = ST_NONE;
        end
      endcase
    end else if (cmd_i.walk_fire) begin
      if (is_tick) begin
        if (live && w_dly == 32'd0) begin
          pnz_d[walk_idx_i] = 1'b1;
        end
        if (walk_idx_i == LastIdx) begin
          o_load = 1'b1;
        end
      end else if (is_disp && run_nz) begin
        o_load            = 1'b1;
        o_slot_d          = 7'(walk_idx_i);
        o_tag_d           = w_tag;
        o_last_d          = !later;
        pnz_d[walk_idx_i] = (run_nx != '0) && (w_per != 32'd0);
        if (w_per == 32'd0) begin
          occ_d[walk_idx_i] = 1'b0;
        end
      end
    end
  end

  // Slot memories: one read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_tag_q <= tag_mem[rd_idx_i];
      rd_dly_q <= dly_mem[rd_idx_i];
      rd_per_q <= per_mem[rd_idx_i];
      rd_run_q <= run_mem[rd_idx_i];
    end
    if (add_wr) begin
      tag_mem[free_idx] <= tag_q;
      dly_mem[free_idx] <= dly_q;
      per_mem[free_idx] <= per_q;
      run_mem[free_idx] <= '0;
    end else if (cmd_i.walk_fire && live) begin
      if (is_tick) begin
        dly_mem[walk_idx_i] <= dly_nx;
        run_mem[walk_idx_i] <= run_nx;
      end else if (is_disp && run_nz) begin
        run_mem[walk_idx_i] <= run_nx;
      end
    end
  end

  // Operand and output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q  <= task_tag_i;
      dly_q  <= first_delay_i;
      per_q  <= period_i;
      sidx_q <= slot_index_i;
    end
    if (o_load) begin
      o_status_q <= o_status_d;
      o_slot_q   <= o_slot_d;
      o_tag_q    <= o_tag_d;
      o_last_q   <= o_last_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      pnz_q     <= '0;
      err_q     <= ERR_NONE;
      out_vld_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      pnz_q <= pnz_d;
      err_q <= err_d;
      if (o_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free   = !out_vld_q || !out_stall_i;
  assign sts_o.walk_emit  = is_tick ? (walk_idx_i == LastIdx) : run_nz;
  assign sts_o.none_ready = (pnz_q == '0);

  assign out_valid_o   = out_vld_q;
  assign status_o      = o_status_q;
  assign slot_o        = o_slot_q;
  assign run_tag_o     = o_tag_q;
  assign last_result_o = o_last_q;
  assign last_error_o  = err_q;

endmodule
